FILE: sv/ufm_pkg.sv
// ============================================================================
// ufm_pkg: shared types for the union-find merge and query block
// Holds the element field width and the command and status groups that pass
// between the controller and the datapath.
// ============================================================================
package ufm_pkg;

	// Width of an element index field on the request channel.
	localparam int unsigned ELEM_W = 8;

	// Request kinds carried in req_type.
	localparam logic REQ_JOIN  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the accepted request
		logic init_a;     // make element a a root of size one
		logic init_b;     // make element b a root of size one
		logic start_a;    // begin the root walk at element a
		logic start_b;    // begin the root walk at element b
		logic save_ra;    // the current element is the root of a
		logic step;       // read the parent of the parent just read
		logic halve;      // link the current element to its grandparent
		logic size_rd_ra; // read the size of root a
		logic size_rd_rb; // keep the size of root a, read the size of root b
		logic link;       // hang the smaller tree under the larger one
		logic finish;     // load the result register
		logic res_same;
		logic res_merged;
	} ufm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_query;
		logic in_range;
		logic a_eq_b;
		logic a_known;
		logic b_known;
		logic cur_is_root;
		logic roots_eq;
		logic out_free;
	} ufm_status_t;

endpackage

FILE: sv/ufm_in_if.sv
// ============================================================================
// ufm_in_if: request channel
// Valid and ready handshake carrying one join or query request.
// ============================================================================
interface ufm_in_if;
	import ufm_pkg::*;

	logic              valid;
	logic              ready;
	logic              req_type;
	logic [ELEM_W-1:0] elem_a;
	logic [ELEM_W-1:0] elem_b;

	modport source (output valid, output req_type, output elem_a, output elem_b, input ready);
	modport sink   (input valid, input req_type, input elem_a, input elem_b, output ready);
endinterface

FILE: sv/ufm_out_if.sv
// ============================================================================
// ufm_out_if: result channel
// Valid and ready handshake carrying one result per request.
// ============================================================================
interface ufm_out_if;
	logic valid;
	logic ready;
	logic same_set;
	logic merged;

	modport source (output valid, output same_set, output merged, input ready);
	modport sink   (input valid, input same_set, input merged, output ready);
endinterface

FILE: sv/union_find_merge_and_query_top.sv
// ============================================================================
// union_find_merge_and_query_top: disjoint-set table with join and query
// Union by size with path halving over a table of NUM_ELEMS elements.
// ============================================================================
// Usage:
// Requests arrive on the req channel. Each transaction carries req_type
// (0 join, 1 query) and two element indices. Every request yields exactly
// one transaction on the rsp channel with same_set and merged.
// One request is worked on at a time. A request ends early when an index is
// out of range, or when a query names the same element twice or an unknown
// element; the controller then goes from the check straight to the finish
// state. Otherwise it makes each new element of a join known, starts the walks
// and confirms each root, runs the halving steps of each root walk, and for a
// real merge does the size compare and link. The result register is loaded
// in the finish state once the output slot is free. The walk speed is set by
// the single read port of the parent memory: every link followed in a walk
// costs one registered read.
// Reset clears the controller, the result valid flag and the known flags.
// The parent and size memories are not cleared: an entry is written together
// with the setting of its known flag, and only known entries are read.
// Stalls: the result sits in an output register, so the next request is
// accepted while a result waits. If a new result is ready while the old one
// is still unclaimed, the controller holds it until rsp.ready frees the slot.
// ============================================================================
module union_find_merge_and_query_top #(
	parameter int unsigned NUM_ELEMS = 256
) (
	input logic     clk,
	input logic     arst_n,
	ufm_in_if.sink  req,
	ufm_out_if.source rsp
);
	import ufm_pkg::*;

	ufm_cmd_t    cmd;
	ufm_status_t st;

	// The controller decides every step; the datapath only executes commands
	// and reports the comparisons it needs.
	ufm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.st       (st),
		.cmd      (cmd)
	);

	// The datapath owns the memories, the known flags and the result register.
	ufm_dp #(.NUM_ELEMS(NUM_ELEMS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_type     (req.req_type),
		.elem_a       (req.elem_a),
		.elem_b       (req.elem_b),
		.rsp_ready    (rsp.ready),
		.rsp_valid    (rsp.valid),
		.rsp_same_set (rsp.same_set),
		.rsp_merged   (rsp.merged),
		.cmd          (cmd),
		.st           (st)
	);
endmodule

FILE: sv/ufm_ram.sv
// ============================================================================
// ufm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module ufm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

FILE: sv/ufm_ctrl.sv
// ============================================================================
// ufm_ctrl: request sequencer
// Steps each request through element setup, the two root walks with path
// halving, the size compare and link, and the hand-off to the result register.
// ============================================================================
module ufm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ufm_pkg::ufm_status_t st,
	output ufm_pkg::ufm_cmd_t    cmd
);
	import ufm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_INIT_A,
		ST_INIT_B,
		ST_START,
		ST_FIND_P,
		ST_FIND_GP,
		ST_SIZE_B,
		ST_LINK,
		ST_FINISH
	} state_t;

	state_t state_q, state_d;
	logic   find_b_q, find_b_d;
	logic   res_same_q, res_same_d;
	logic   res_merged_q, res_merged_d;

	always_comb begin
		cmd          = '0;
		in_ready     = 1'b0;
		state_d      = state_q;
		find_b_d     = find_b_q;
		res_same_d   = res_same_q;
		res_merged_d = res_merged_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				res_merged_d = 1'b0;
				res_same_d   = 1'b0;
				find_b_d     = 1'b0;
				if (!st.in_range) begin
					res_same_d = st.a_eq_b;
					state_d    = ST_FINISH;
				end else if (st.is_query) begin
					if (st.a_eq_b) begin
						res_same_d = 1'b1;
						state_d    = ST_FINISH;
					end else if (st.a_known && st.b_known) begin
						state_d = ST_START;
					end else begin
						state_d = ST_FINISH;
					end
				end else if (!st.a_known) begin
					state_d = ST_INIT_A;
				end else if (!st.b_known) begin
					state_d = ST_INIT_B;
				end else begin
					state_d = ST_START;
				end
			end
			ST_INIT_A: begin
				cmd.init_a = 1'b1;
				state_d    = (!st.b_known && !st.a_eq_b) ? ST_INIT_B : ST_START;
			end
			ST_INIT_B: begin
				cmd.init_b = 1'b1;
				state_d    = ST_START;
			end
			ST_START: begin
				cmd.start_a = 1'b1;
				state_d     = ST_FIND_P;
			end
			ST_FIND_P: begin
				if (st.cur_is_root) begin
					if (!find_b_q) begin
						cmd.save_ra = 1'b1;
						cmd.start_b = 1'b1;
						find_b_d    = 1'b1;
					end else if (st.is_query || st.roots_eq) begin
						// A join only lands here when both roots already match.
						res_same_d   = st.roots_eq;
						res_merged_d = 1'b0;
						state_d      = ST_FINISH;
					end else begin
						cmd.size_rd_ra = 1'b1;
						state_d        = ST_SIZE_B;
					end
				end else begin
					cmd.step = 1'b1;
					state_d  = ST_FIND_GP;
				end
			end
			ST_FIND_GP: begin
				cmd.halve = 1'b1;
				state_d   = ST_FIND_P;
			end
			ST_SIZE_B: begin
				cmd.size_rd_rb = 1'b1;
				state_d        = ST_LINK;
			end
			ST_LINK: begin
				cmd.link     = 1'b1;
				res_same_d   = 1'b1;
				res_merged_d = 1'b1;
				state_d      = ST_FINISH;
			end
			ST_FINISH: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		cmd.res_same   = res_same_q;
		cmd.res_merged = res_merged_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			find_b_q     <= 1'b0;
			res_same_q   <= 1'b0;
			res_merged_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			find_b_q     <= find_b_d;
			res_same_q   <= res_same_d;
			res_merged_q <= res_merged_d;
		end
	end
endmodule

FILE: sv/ufm_dp.sv
// ============================================================================
// ufm_dp: union-find datapath
// Known flags, parent and size memories, walk registers, the size compare and
// the result register.
// ============================================================================
module ufm_dp #(
	parameter int unsigned NUM_ELEMS = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_type,
	input  logic [ufm_pkg::ELEM_W-1:0]  elem_a,
	input  logic [ufm_pkg::ELEM_W-1:0]  elem_b,
	input  logic                        rsp_ready,
	output logic                        rsp_valid,
	output logic                        rsp_same_set,
	output logic                        rsp_merged,
	input  ufm_pkg::ufm_cmd_t           cmd,
	output ufm_pkg::ufm_status_t        st
);
	import ufm_pkg::*;

	// Only indices that fit the element field can ever be reached.
	localparam int unsigned FIELD_SPAN = 1 << ELEM_W;
	localparam int unsigned DEPTH = (NUM_ELEMS < FIELD_SPAN) ? NUM_ELEMS : FIELD_SPAN;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned SW    = $clog2(DEPTH + 1);

	logic              req_type_q;
	logic [ELEM_W-1:0] a_q;
	logic [ELEM_W-1:0] b_q;
	logic [AW-1:0]     cur_q;
	logic [AW-1:0]     ra_q;
	logic [SW-1:0]     sza_q;
	logic [DEPTH-1:0]  known_q;
	logic              out_valid_q;
	logic              out_same_q;
	logic              out_merged_q;

	logic [AW-1:0] a_idx;
	logic [AW-1:0] b_idx;

	logic          par_wr_en;
	logic [AW-1:0] par_wr_addr;
	logic [AW-1:0] par_wr_data;
	logic          par_rd_en;
	logic [AW-1:0] par_rd_addr;
	logic [AW-1:0] par_rd_data;

	logic          sz_wr_en;
	logic [AW-1:0] sz_wr_addr;
	logic [SW-1:0] sz_wr_data;
	logic          sz_rd_en;
	logic [AW-1:0] sz_rd_addr;
	logic [SW-1:0] sz_rd_data;

	logic          a_top;
	logic [AW-1:0] top_idx;
	logic [AW-1:0] low_idx;

	assign a_idx = a_q[AW-1:0];
	assign b_idx = b_q[AW-1:0];

	assign st.is_query    = (req_type_q == REQ_QUERY);
	assign st.in_range    = (32'(a_q) < 32'(NUM_ELEMS)) && (32'(b_q) < 32'(NUM_ELEMS));
	assign st.a_eq_b      = (a_q == b_q);
	assign st.a_known     = known_q[a_idx];
	assign st.b_known     = known_q[b_idx];
	assign st.cur_is_root = (par_rd_data == cur_q);
	assign st.roots_eq    = (ra_q == cur_q);
	assign st.out_free    = !out_valid_q || rsp_ready;

	// Link step: the current element holds root b, the size memory holds its size.
	assign a_top   = (sza_q > sz_rd_data);
	assign top_idx = a_top ? ra_q : cur_q;
	assign low_idx = a_top ? cur_q : ra_q;

	always_comb begin
		par_wr_en   = 1'b0;
		par_wr_addr = cur_q;
		par_wr_data = par_rd_data;
		sz_wr_en    = 1'b0;
		sz_wr_addr  = top_idx;
		sz_wr_data  = SW'(sza_q + sz_rd_data);
		if (cmd.init_a) begin
			par_wr_en   = 1'b1;
			par_wr_addr = a_idx;
			par_wr_data = a_idx;
			sz_wr_en    = 1'b1;
			sz_wr_addr  = a_idx;
			sz_wr_data  = SW'(1);
		end else if (cmd.init_b) begin
			par_wr_en   = 1'b1;
			par_wr_addr = b_idx;
			par_wr_data = b_idx;
			sz_wr_en    = 1'b1;
			sz_wr_addr  = b_idx;
			sz_wr_data  = SW'(1);
		end else if (cmd.halve) begin
			par_wr_en = 1'b1;
		end else if (cmd.link) begin
			par_wr_en   = 1'b1;
			par_wr_addr = low_idx;
			par_wr_data = top_idx;
			sz_wr_en    = 1'b1;
		end
	end

	always_comb begin
		par_rd_en   = cmd.start_a || cmd.start_b || cmd.step || cmd.halve;
		par_rd_addr = par_rd_data;
		if (cmd.start_a) begin
			par_rd_addr = a_idx;
		end else if (cmd.start_b) begin
			par_rd_addr = b_idx;
		end
		sz_rd_en   = cmd.size_rd_ra || cmd.size_rd_rb;
		sz_rd_addr = cmd.size_rd_ra ? ra_q : cur_q;
	end

	ufm_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_parent (
		.clk     (clk),
		.wr_en   (par_wr_en),
		.wr_addr (par_wr_addr),
		.wr_data (par_wr_data),
		.rd_en   (par_rd_en),
		.rd_addr (par_rd_addr),
		.rd_data (par_rd_data)
	);

	ufm_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_size (
		.clk     (clk),
		.wr_en   (sz_wr_en),
		.wr_addr (sz_wr_addr),
		.wr_data (sz_wr_data),
		.rd_en   (sz_rd_en),
		.rd_addr (sz_rd_addr),
		.rd_data (sz_rd_data)
	);

	// Walk and request registers hold payload only.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= req_type;
			a_q        <= elem_a;
			b_q        <= elem_b;
		end
		if (cmd.start_a) begin
			cur_q <= a_idx;
		end else if (cmd.start_b) begin
			cur_q <= b_idx;
		end else if (cmd.halve) begin
			cur_q <= par_rd_data;
		end
		if (cmd.save_ra) begin
			ra_q <= cur_q;
		end
		if (cmd.size_rd_rb) begin
			sza_q <= sz_rd_data;
		end
		if (cmd.finish) begin
			out_same_q   <= cmd.res_same;
			out_merged_q <= cmd.res_merged;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.init_a) begin
				known_q[a_idx] <= 1'b1;
			end
			if (cmd.init_b) begin
				known_q[b_idx] <= 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid    = out_valid_q;
	assign rsp_same_set = out_same_q;
	assign rsp_merged   = out_merged_q;
endmodule
